// File: hw/rtl/edge_list_to_csr_builder_top_defines.svh
// Assertion macros of the CSR builder RTL, used by the controller.
`ifndef EDGE_LIST_TO_CSR_BUILDER_TOP_DEFINES_SVH
`define EDGE_LIST_TO_CSR_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ECSR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecsr check failed in %m");

// Next-cycle implication, disabled while reset is high.
`define ECSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecsr check failed in %m");

`endif

// File: hw/rtl/ecsr_pkg.sv
// Shared widths, codes and controller/datapath structs for the CSR builder.
`timescale 1ns / 1ps

package ecsr_pkg;

  localparam int OP_W          = 2;
  localparam int NODE_W        = 10;
  localparam int INDEX_W       = 13;
  localparam int VALUE_W       = 13;
  localparam int STATUS_W      = 2;
  localparam int NUM_NODES_W   = 11;
  localparam int NUM_NODES_RST = 1024;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_BUILD    = 2'd1,
    OP_READ_ROW = 2'd2,
    OP_READ_NBR = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_READ = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OSEL_ZERO   = 3'd0,
    OSEL_COUNT  = 3'd1,
    OSEL_PLACED = 3'd2,
    OSEL_ACC    = 3'd3,
    OSEL_ROW    = 3'd4,
    OSEL_NBR    = 3'd5
  } out_sel_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic     capture;
    logic     clr_start;
    logic     clr_step;
    logic     ld_rd;
    logic     ld_wr;
    logic     ps_start;
    logic     ps_rd;
    logic     ps_wr;
    logic     sc_start;
    logic     sc_rd;
    logic     sc_cur;
    logic     sc_wr;
    logic     sc_next;
    logic     build_done;
    logic     rd_row;
    logic     rd_nbr;
    logic     out_load;
    out_sel_t out_sel;
    status_t  out_status;
  } ctl_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    op_t  op;
    logic built;
    logic node_ok;
    logic full;
    logic row_ok;
    logic nbr_ok;
    logic clr_last;
    logic ps_last;
    logic sc_empty;
    logic sc_last;
    logic sc_src_ok;
    logic out_free;
  } ctl_sts_t;

endpackage

// File: hw/rtl/ecsr_if.sv
// Channel interfaces of the CSR builder: command, response and configuration.
`timescale 1ns / 1ps

interface ecsr_cmd_if import ecsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [NODE_W-1:0]  src_node;
  logic [NODE_W-1:0]  dst_node;
  logic [INDEX_W-1:0] index;

  modport source (output valid, op, src_node, dst_node, index, input ready);
  modport sink   (input valid, op, src_node, dst_node, index, output ready);
endinterface

interface ecsr_rsp_if import ecsr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

interface ecsr_cfg_if import ecsr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [NUM_NODES_W-1:0] num_nodes;

  modport source (output valid, num_nodes, input ready);
  modport sink   (input valid, num_nodes, output ready);
endinterface

// File: hw/rtl/edge_list_to_csr_builder_top.sv
// Top level of the edge-list to CSR graph builder.
`timescale 1ns / 1ps
// Usage:
//   cmd : one beat per item (op, src_node, dst_node, index); load edge, build,
//         read row start, read neighbour. Accepted when valid and ready are high.
//   rsp : exactly one beat (value, status) per accepted item, in order, held in
//         an output register until taken.
//   cfg : writes num_nodes whenever valid is high; ready is always high.
// Flow: one item is in work at a time; the next beat is taken once the
//   controller is back in idle after the result is loaded. A load is a
//   read-modify-write of the degree count in the row store through its
//   registered read port; a read waits on the registered read of its store.
//   Build: a prefix sum over the N nodes (one row store read and write per
//   node), then a scatter of each stored edge through the edge, cursor and
//   neighbour stores; an edge whose source is out of the node limit is
//   skipped without a cursor or neighbour write.
//   The first load after a build first clears the row store: a clear pass,
//   then a second decode of the same beat.
// Reset: synchronous, active high. After it every row of the row store is
//   cleared, one row a cycle, while cmd.ready stays low.
// Stall: while a result waits on rsp, no new beat is accepted unless rsp is
//   taken in the same cycle; nothing is dropped.

module edge_list_to_csr_builder_top import ecsr_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic        clk,
  input  logic        rst,
  ecsr_cfg_if.sink    cfg,
  ecsr_cmd_if.sink    cmd,
  ecsr_rsp_if.source  rsp
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  // the node count register takes every write beat
  assign cfg.ready = 1'b1;

  ecsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  ecsr_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd_op        (cmd.op),
    .cmd_src_node  (cmd.src_node),
    .cmd_dst_node  (cmd.dst_node),
    .cmd_index     (cmd.index),
    .cfg_valid     (cfg.valid),
    .cfg_num_nodes (cfg.num_nodes),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value     (rsp.value),
    .rsp_status    (rsp.status)
  );

endmodule

// File: hw/rtl/ecsr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module ecsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ecsr_ctrl.sv
// Sequencer of the CSR builder: clear pass, load, build phases and reads.
`timescale 1ns / 1ps
`include "edge_list_to_csr_builder_top_defines.svh"

module ecsr_ctrl import ecsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  output ctl_cmd_t ctl,
  input  ctl_sts_t sts
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_DECODE  = 10'b00_0000_0100,
    S_LD_WR   = 10'b00_0000_1000,
    S_PS_RD   = 10'b00_0001_0000,
    S_PS_WR   = 10'b00_0010_0000,
    S_SC_RD   = 10'b00_0100_0000,
    S_SC_CUR  = 10'b00_1000_0000,
    S_SC_WR   = 10'b01_0000_0000,
    S_RD_WAIT = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   clr_resume;  // clear pass was started by a load, go back and run it

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_resume <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.clr_start) begin
        clr_resume <= 1'b1;
      end else if (state == S_CLEAR && sts.clr_last) begin
        clr_resume <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = clr_resume ? S_DECODE : S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_ready = sts.out_free;
        if (cmd_valid && sts.out_free) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_LOAD: begin
            if (sts.built) begin
              // new graph: wipe the counts first, then retry this beat
              ctl.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end else if (!sts.node_ok) begin
              ctl.out_load   = 1'b1;
              ctl.out_sel    = OSEL_ZERO;
              ctl.out_status = ST_RANGE;
              state_next     = S_IDLE;
            end else if (sts.full) begin
              ctl.out_load   = 1'b1;
              ctl.out_sel    = OSEL_ZERO;
              ctl.out_status = ST_FULL;
              state_next     = S_IDLE;
            end else begin
              ctl.ld_rd  = 1'b1;
              state_next = S_LD_WR;
            end
          end
          OP_BUILD: begin
            if (sts.built) begin
              ctl.out_load   = 1'b1;
              ctl.out_sel    = OSEL_PLACED;
              ctl.out_status = ST_OK;
              state_next     = S_IDLE;
            end else begin
              ctl.ps_start = 1'b1;
              state_next   = S_PS_RD;
            end
          end
          OP_READ_ROW: begin
            if (!sts.built || !sts.row_ok) begin
              ctl.out_load   = 1'b1;
              ctl.out_sel    = OSEL_ZERO;
              ctl.out_status = ST_BAD_READ;
              state_next     = S_IDLE;
            end else begin
              ctl.rd_row = 1'b1;
              state_next = S_RD_WAIT;
            end
          end
          OP_READ_NBR: begin
            if (!sts.built || !sts.nbr_ok) begin
              ctl.out_load   = 1'b1;
              ctl.out_sel    = OSEL_ZERO;
              ctl.out_status = ST_BAD_READ;
              state_next     = S_IDLE;
            end else begin
              ctl.rd_nbr = 1'b1;
              state_next = S_RD_WAIT;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_LD_WR: begin
        ctl.ld_wr      = 1'b1;
        ctl.out_load   = 1'b1;
        ctl.out_sel    = OSEL_COUNT;
        ctl.out_status = ST_OK;
        state_next     = S_IDLE;
      end
      S_PS_RD: begin
        ctl.ps_rd  = 1'b1;
        state_next = S_PS_WR;
      end
      S_PS_WR: begin
        ctl.ps_wr = 1'b1;
        if (!sts.ps_last) begin
          state_next = S_PS_RD;
        end else if (sts.sc_empty) begin
          ctl.build_done = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_sel    = OSEL_ACC;
          ctl.out_status = ST_OK;
          state_next     = S_IDLE;
        end else begin
          ctl.sc_start = 1'b1;
          state_next   = S_SC_RD;
        end
      end
      S_SC_RD: begin
        ctl.sc_rd  = 1'b1;
        state_next = S_SC_CUR;
      end
      S_SC_CUR: begin
        if (sts.sc_src_ok) begin
          ctl.sc_cur = 1'b1;
          state_next = S_SC_WR;
        end else if (sts.sc_last) begin
          ctl.build_done = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_sel    = OSEL_ACC;
          ctl.out_status = ST_OK;
          state_next     = S_IDLE;
        end else begin
          ctl.sc_next = 1'b1;
          state_next  = S_SC_RD;
        end
      end
      S_SC_WR: begin
        ctl.sc_wr = 1'b1;
        if (sts.sc_last) begin
          ctl.build_done = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_sel    = OSEL_ACC;
          ctl.out_status = ST_OK;
          state_next     = S_IDLE;
        end else begin
          ctl.sc_next = 1'b1;
          state_next  = S_SC_RD;
        end
      end
      S_RD_WAIT: begin
        ctl.out_load   = 1'b1;
        ctl.out_sel    = (sts.op == OP_READ_ROW) ? OSEL_ROW : OSEL_NBR;
        ctl.out_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a result never overwrites one that is still waiting
  `ECSR_ASSERT_NOW(a_no_overwrite, clk, rst, ctl.out_load, sts.out_free)
  // every result ends the item's work
  `ECSR_ASSERT_NEXT(a_result_ends_item, clk, rst, ctl.out_load, state == S_IDLE)
  // an accepted beat is always decoded next
  `ECSR_ASSERT_NEXT(a_capture_decode, clk, rst, ctl.capture, state == S_DECODE)

endmodule

// File: hw/rtl/ecsr_dp.sv
// Datapath of the CSR builder: edge, row, cursor and neighbour stores and counters.
`timescale 1ns / 1ps

module ecsr_dp import ecsr_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_cmd_t               ctl,
  output ctl_sts_t               sts,
  input  logic [OP_W-1:0]        cmd_op,
  input  logic [NODE_W-1:0]      cmd_src_node,
  input  logic [NODE_W-1:0]      cmd_dst_node,
  input  logic [INDEX_W-1:0]     cmd_index,
  input  logic                   cfg_valid,
  input  logic [NUM_NODES_W-1:0] cfg_num_nodes,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic [VALUE_W-1:0]     rsp_value,
  output logic [STATUS_W-1:0]    rsp_status
);

  localparam int NNW = $clog2(MAX_NODES + 1);  // node count, row store address
  localparam int NAW = $clog2(MAX_NODES);      // node id
  localparam int EW  = $clog2(MAX_EDGES + 1);  // edge count
  localparam int EAW = $clog2(MAX_EDGES);      // edge position
  localparam int CTW = (NNW > EW) ? NNW : EW;
  localparam int CW0 = (NNW > EW) ? NNW : EW;
  localparam int CW  = (CW0 > INDEX_W) ? CW0 : INDEX_W;  // compare width

  op_t                    item_op;
  logic [NODE_W-1:0]      item_src;
  logic [NODE_W-1:0]      item_dst;
  logic [INDEX_W-1:0]     item_idx;
  logic [NUM_NODES_W-1:0] num_nodes;
  logic [EW-1:0]          edge_count;
  logic                   built;
  logic [NNW-1:0]         built_nodes;
  logic [EW-1:0]          placed;
  logic [NNW-1:0]         n_build;
  logic [EW-1:0]          acc;
  logic [CTW-1:0]         ctr;
  logic                   out_valid;
  logic [VALUE_W-1:0]     out_value;
  status_t                out_status;

  logic [CW-1:0]  cfg_x;
  logic [CW-1:0]  lim;
  logic [NNW-1:0] src_inc;

  logic           row_we, row_re;
  logic [NNW-1:0] row_wa, row_ra;
  logic [EW-1:0]  row_wd, row_rd;

  logic           cur_we, cur_re;
  logic [NAW-1:0] cur_wa;
  logic [EW-1:0]  cur_wd, cur_rd;

  logic [2*NAW-1:0] edge_wd, edge_rd;
  logic [NAW-1:0]   edge_src, edge_dst;
  logic [NAW-1:0]   nbr_rd;

  logic [VALUE_W-1:0] out_mux;

  // node count in force, clamped to 1..MAX_NODES
  always_comb begin
    cfg_x = CW'(num_nodes);
    if (cfg_x == '0) begin
      lim = CW'(1);
    end else if (cfg_x > CW'(MAX_NODES)) begin
      lim = CW'(MAX_NODES);
    end else begin
      lim = cfg_x;
    end
  end

  assign src_inc  = NNW'(CW'(item_src) + CW'(1));
  assign edge_src = edge_rd[2*NAW-1:NAW];
  assign edge_dst = edge_rd[NAW-1:0];
  assign edge_wd  = {NAW'(item_src), NAW'(item_dst)};

  // row store: degree counts while loading, row starts after build
  always_comb begin
    row_we = ctl.clr_step | ctl.ld_wr | ctl.ps_wr;
    row_wa = NNW'(ctr);
    row_wd = '0;
    if (ctl.ld_wr) begin
      row_wa = src_inc;
      row_wd = row_rd + EW'(1);
    end else if (ctl.ps_wr) begin
      row_wd = acc + row_rd;
    end
    row_re = ctl.ld_rd | ctl.ps_rd | ctl.rd_row;
    if (ctl.ld_rd) begin
      row_ra = src_inc;
    end else if (ctl.ps_rd) begin
      row_ra = NNW'(ctr);
    end else begin
      row_ra = NNW'(item_idx);
    end
  end

  always_comb begin
    cur_we = ctl.ps_wr | ctl.sc_wr;
    cur_re = ctl.sc_cur;
    if (ctl.ps_wr) begin
      cur_wa = NAW'(ctr - CTW'(1));
      cur_wd = acc;
    end else begin
      cur_wa = edge_src;
      cur_wd = cur_rd + EW'(1);
    end
  end

  ecsr_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_wa),
    .wr_data (row_wd),
    .rd_en   (row_re),
    .rd_addr (row_ra),
    .rd_data (row_rd)
  );

  ecsr_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_cur_ram (
    .clk     (clk),
    .wr_en   (cur_we),
    .wr_addr (cur_wa),
    .wr_data (cur_wd),
    .rd_en   (cur_re),
    .rd_addr (edge_src),
    .rd_data (cur_rd)
  );

  ecsr_ram #(.WIDTH(2 * NAW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk     (clk),
    .wr_en   (ctl.ld_wr),
    .wr_addr (EAW'(edge_count)),
    .wr_data (edge_wd),
    .rd_en   (ctl.sc_rd),
    .rd_addr (EAW'(ctr)),
    .rd_data (edge_rd)
  );

  ecsr_ram #(.WIDTH(NAW), .DEPTH(MAX_EDGES)) u_nbr_ram (
    .clk     (clk),
    .wr_en   (ctl.sc_wr),
    .wr_addr (EAW'(cur_rd)),
    .wr_data (edge_dst),
    .rd_en   (ctl.rd_nbr),
    .rd_addr (EAW'(item_idx)),
    .rd_data (nbr_rd)
  );

  always_comb begin
    sts.op        = item_op;
    sts.built     = built;
    sts.node_ok   = (CW'(item_src) < lim) && (CW'(item_dst) < lim);
    sts.full      = (edge_count == EW'(MAX_EDGES));
    sts.row_ok    = (CW'(item_idx) <= CW'(built_nodes));
    sts.nbr_ok    = (CW'(item_idx) < CW'(placed));
    sts.clr_last  = (ctr == CTW'(MAX_NODES));
    sts.ps_last   = (ctr == CTW'(n_build));
    sts.sc_empty  = (edge_count == '0);
    sts.sc_last   = ((ctr + CTW'(1)) == CTW'(edge_count));
    sts.sc_src_ok = (CW'(edge_src) < CW'(n_build));
    sts.out_free  = !out_valid || rsp_ready;
  end

  always_comb begin
    case (ctl.out_sel)
      OSEL_ZERO:   out_mux = '0;
      OSEL_COUNT:  out_mux = VALUE_W'(edge_count + EW'(1));
      OSEL_PLACED: out_mux = VALUE_W'(placed);
      OSEL_ACC:    out_mux = VALUE_W'(acc);
      OSEL_ROW:    out_mux = VALUE_W'(row_rd);
      OSEL_NBR:    out_mux = VALUE_W'(nbr_rd);
      default:     out_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes   <= NUM_NODES_W'(NUM_NODES_RST);
      edge_count  <= '0;
      built       <= 1'b0;
      built_nodes <= NNW'(1);
      placed      <= '0;
      ctr         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        num_nodes <= cfg_num_nodes;
      end
      if (ctl.clr_start || ctl.sc_start) begin
        ctr <= '0;
      end else if (ctl.ps_start) begin
        ctr <= CTW'(1);
      end else if (ctl.clr_step || ctl.ps_wr || ctl.sc_next) begin
        ctr <= ctr + CTW'(1);
      end
      if (ctl.clr_start) begin
        built      <= 1'b0;
        edge_count <= '0;
      end else if (ctl.ld_wr) begin
        edge_count <= edge_count + EW'(1);
      end
      if (ctl.build_done) begin
        built       <= 1'b1;
        built_nodes <= n_build;
        placed      <= acc;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_op  <= op_t'(cmd_op);
      item_src <= cmd_src_node;
      item_dst <= cmd_dst_node;
      item_idx <= cmd_index;
    end
    if (ctl.ps_start) begin
      n_build <= NNW'(lim);
      acc     <= '0;
    end else if (ctl.ps_wr) begin
      acc <= acc + row_rd;
    end
    if (ctl.out_load) begin
      out_value  <= out_mux;
      out_status <= ctl.out_status;
    end
  end

  assign rsp_valid  = out_valid;
  assign rsp_value  = out_value;
  assign rsp_status = out_status;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the edge-list to CSR graph builder.
`timescale 1ns / 1ps

module tb_top;
  import ecsr_pkg::*;

  localparam int MAX_NODES     = DEF_MAX_NODES;
  localparam int MAX_EDGES     = DEF_MAX_EDGES;
  localparam int SETTLE_CYCLES = 6;          // block is already idle when its last beat is taken
  localparam int END_CYCLES    = 20;
  localparam int CYCLE_LIMIT   = 1_500_000;  // watchdog limit for the whole run
  localparam int RANDOM_ITEMS  = 550;
  localparam int IDLE_PCT      = 32;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } csr_result_t;

  logic clk;
  logic rst;

  ecsr_cfg_if cfg_ch ();
  ecsr_cmd_if cmd_ch ();
  ecsr_rsp_if rsp_ch ();

  edge_list_to_csr_builder_top #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Predicted graph state, updated as each command beat is accepted.
  int unsigned graph_edge_src [MAX_EDGES];
  int unsigned graph_edge_dst [MAX_EDGES];
  int unsigned graph_row_start [MAX_NODES + 1];
  int unsigned graph_cursor [MAX_NODES];
  int unsigned graph_nbr [MAX_EDGES];
  int unsigned graph_edge_count;
  int unsigned graph_built_nodes;
  bit          graph_built;
  logic [NUM_NODES_W-1:0] graph_num_nodes;

  csr_result_t expected_results [$];
  csr_result_t oldest;

  int  fail_count;
  int  cycle_count;
  int  items_sent;
  int  builds_sent;
  int  reads_sent;
  int  cfg_writes;
  bit  quiet;  // no idling on either side while set

  // Clock, 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned node_limit();
    if (graph_num_nodes < 1) return 1;
    if (graph_num_nodes > MAX_NODES) return MAX_NODES;
    return graph_num_nodes;
  endfunction

  function automatic void reset_graph();
    graph_num_nodes   = NUM_NODES_RST;
    foreach (graph_row_start[u]) graph_row_start[u] = 0;
    graph_edge_count  = 0;
    graph_built       = 1'b0;
    graph_built_nodes = 1;
  endfunction

  // Exclusive prefix sum over the degree counts, then scatter in arrival order.
  function automatic void build_csr();
    int unsigned n;
    int unsigned s;
    int unsigned pos;
    n = node_limit();
    for (int unsigned u = 0; u < n; u++) graph_row_start[u + 1] += graph_row_start[u];
    for (int unsigned u = 0; u < n; u++) graph_cursor[u] = graph_row_start[u];
    for (int unsigned i = 0; i < graph_edge_count; i++) begin
      s = graph_edge_src[i];
      if (s < n) begin
        pos = graph_cursor[s];
        if (pos < MAX_EDGES) graph_nbr[pos] = graph_edge_dst[i];
        graph_cursor[s] = pos + 1;
      end
    end
    graph_built_nodes = n;
    graph_built       = 1'b1;
  endfunction

  function automatic csr_result_t predict_result(op_t op, logic [NODE_W-1:0] src,
                                                 logic [NODE_W-1:0] dst,
                                                 logic [INDEX_W-1:0] idx);
    csr_result_t res;
    int unsigned value;
    int unsigned n;
    status_t     st;
    value = 0;
    st    = ST_OK;
    case (op)
      OP_LOAD: begin
        // first load after a build starts a new graph, even if rejected
        if (graph_built) begin
          foreach (graph_row_start[u]) graph_row_start[u] = 0;
          graph_edge_count = 0;
          graph_built      = 1'b0;
        end
        n = node_limit();
        if (src >= n || dst >= n) begin
          st = ST_RANGE;
        end else if (graph_edge_count >= MAX_EDGES) begin
          st = ST_FULL;
        end else begin
          graph_edge_src[graph_edge_count] = src;
          graph_edge_dst[graph_edge_count] = dst;
          graph_edge_count++;
          graph_row_start[src + 1]++;
          value = graph_edge_count;
        end
      end
      OP_BUILD: begin
        if (!graph_built) build_csr();
        value = graph_row_start[graph_built_nodes];
      end
      OP_READ_ROW: begin
        if (graph_built && idx <= graph_built_nodes) value = graph_row_start[idx];
        else st = ST_BAD_READ;
      end
      default: begin
        if (graph_built && idx < graph_row_start[graph_built_nodes] && idx < MAX_EDGES)
          value = graph_nbr[idx];
        else st = ST_BAD_READ;
      end
    endcase
    res.value  = value[VALUE_W-1:0];
    res.status = st;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  // One command beat; valid stays high on return so back-to-back beats need no toggle.
  task automatic send_item(op_t op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                           logic [INDEX_W-1:0] idx);
    csr_result_t predicted;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.op       <= op;
    cmd_ch.src_node <= src;
    cmd_ch.dst_node <= dst;
    cmd_ch.index    <= idx;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predicted        = predict_result(op, src, dst, idx);
    expected_results = {expected_results, predicted};
    items_sent++;
    if (op == OP_BUILD) builds_sent++;
    if (op == OP_READ_ROW || op == OP_READ_NBR) reads_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    send_item(OP_LOAD, src, dst, INDEX_W'($urandom()));
  endtask

  task automatic send_build();
    send_item(OP_BUILD, NODE_W'($urandom()), NODE_W'($urandom()), INDEX_W'($urandom()));
  endtask

  task automatic send_read(op_t op, logic [INDEX_W-1:0] idx);
    send_item(op, NODE_W'($urandom()), NODE_W'($urandom()), idx);
  endtask

  // Stop sending and let every outstanding beat come back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic set_node_count(logic [NUM_NODES_W-1:0] n);
    drain_results();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.num_nodes <= n;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    graph_num_nodes = n;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Response side: random back-pressure, sampled at the rising edge.
  always @(negedge clk) begin
    rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("response beat with nothing outstanding: value %0d status %0d",
               rsp_ch.value, rsp_ch.status);
        fail_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (rsp_ch.value !== oldest.value) begin
          $error("value: expected %0d, got %0d", oldest.value, rsp_ch.value);
          fail_count++;
        end
        if (rsp_ch.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("edge_list_to_csr_builder_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reads before any build, a small graph, repeated build, read bounds, new graph.
  task automatic test_basic_graph();
    set_node_count(11'd8);
    send_read(OP_READ_ROW, 13'd0);
    send_read(OP_READ_NBR, 13'd8191);
    send_load(10'd0, 10'd1);
    send_load(10'd0, 10'd7);
    send_load(10'd7, 10'd0);
    send_load(10'd3, 10'd3);
    send_load(10'd8, 10'd0);        // src out of range
    send_load(10'd0, 10'd1023);     // dst out of range
    send_load(10'd1023, 10'd1023);
    send_build();
    send_build();                   // repeat: nothing changes
    send_read(OP_READ_ROW, 13'd0);
    send_read(OP_READ_ROW, 13'd8);  // last row start, equals built node count
    send_read(OP_READ_ROW, 13'd9);
    send_read(OP_READ_ROW, 13'd8191);
    send_read(OP_READ_NBR, 13'd0);
    send_read(OP_READ_NBR, 13'd3);
    send_read(OP_READ_NBR, 13'd4);
    send_read(OP_READ_NBR, 13'd4096);
    send_load(10'd1023, 10'd0);     // rejected, but still clears the graph
    send_read(OP_READ_ROW, 13'd0);  // premature again
    send_build();                   // empty graph
    send_read(OP_READ_NBR, 13'd0);
  endtask

  // Register extremes: 0 and 2047 clamp, 1 and 1024 are the true bounds.
  task automatic test_node_count_extremes();
    set_node_count(11'd0);
    send_load(10'd0, 10'd0);
    send_load(10'd1, 10'd0);
    send_build();
    send_read(OP_READ_ROW, 13'd1);
    send_read(OP_READ_ROW, 13'd2);
    set_node_count(11'd2047);
    send_load(10'd1023, 10'd512);
    send_load(10'd512, 10'd1023);
    send_load(10'd1023, 10'd0);
    send_build();
    send_read(OP_READ_ROW, 13'd1024);
    send_read(OP_READ_ROW, 13'd1025);
    send_read(OP_READ_NBR, 13'd2);
    set_node_count(11'd1);
    send_load(10'd0, 10'd0);
    send_load(10'd0, 10'd1);
    send_build();
    set_node_count(11'd1024);
    send_load(10'd1023, 10'd1023);
    send_build();
    send_read(OP_READ_NBR, 13'd0);
  endtask

  // Node count lowered between loads and build: high sources are dropped.
  task automatic test_count_change_before_build();
    set_node_count(11'd16);
    send_load(10'd15, 10'd2);
    send_load(10'd1, 10'd14);
    send_load(10'd6, 10'd5);
    send_load(10'd2, 10'd9);
    send_load(10'd1, 10'd3);
    set_node_count(11'd4);
    send_build();
    send_read(OP_READ_ROW, 13'd4);
    send_read(OP_READ_NBR, 13'd2);
    send_read(OP_READ_NBR, 13'd3);
  endtask

  // Fill the edge store, then hit the full and out-of-range paths.
  task automatic test_store_full();
    set_node_count(11'd1024);
    quiet = 1'b1;
    send_load(10'd0, 10'd0);        // starts a new graph
    while (graph_edge_count < MAX_EDGES)
      send_load(NODE_W'($urandom()), NODE_W'($urandom()));
    quiet = 1'b0;
    send_load(10'd1, 10'd2);
    send_load(10'd1023, 10'd1023);
    set_node_count(11'd16);
    send_load(10'd20, 10'd0);       // range is checked ahead of full
    send_load(10'd3, 10'd3);
    set_node_count(11'd1024);
    send_build();
    send_read(OP_READ_ROW, 13'd1024);
    send_read(OP_READ_NBR, 13'd4095);
    send_read(OP_READ_NBR, 13'd0);
    send_read(OP_READ_NBR, 13'd4096);
  endtask

  // Random graphs: load phase, build, read phase, with noise mixed in.
  task automatic test_random_graphs();
    int phase;
    int n_loads;
    int n_reads;
    int pick;
    int unsigned lim;
    int unsigned placed;
    int start_items;
    phase       = 0;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      if (pick <= 6) set_node_count(11'($urandom_range(40, 2)));
      else if (pick == 7) set_node_count(11'd1024);
      else if (pick == 8) set_node_count(11'($urandom_range(2047)));
      else set_node_count(11'($urandom_range(4, 1)));
      quiet = (phase == 4 || phase == 5);

      n_loads = $urandom_range(30, 1);
      for (int k = 0; k < n_loads; k++) begin
        lim = node_limit();
        if ($urandom_range(9) == 0)
          send_load(NODE_W'($urandom()), NODE_W'($urandom()));
        else
          send_load(NODE_W'($urandom_range(lim - 1)), NODE_W'($urandom_range(lim - 1)));
        if ($urandom_range(19) == 0)
          send_read(op_t'($urandom_range(3, 2)), INDEX_W'($urandom()));
      end

      if ($urandom_range(4) == 0) set_node_count(11'($urandom_range(40, 1)));
      send_build();
      if ($urandom_range(3) == 0) send_build();
      if ($urandom_range(5) == 0) drain_results();  // hold off until all results are in

      n_reads = $urandom_range(25, 5);
      placed  = graph_row_start[graph_built_nodes];
      for (int k = 0; k < n_reads; k++) begin
        if ($urandom_range(1) == 0) begin
          if ($urandom_range(4) != 0)
            send_read(OP_READ_ROW, INDEX_W'($urandom_range(graph_built_nodes)));
          else
            send_read(OP_READ_ROW, INDEX_W'($urandom()));
        end else begin
          if (placed > 0 && $urandom_range(4) != 0)
            send_read(OP_READ_NBR, INDEX_W'($urandom_range(placed - 1)));
          else
            send_read(OP_READ_NBR, INDEX_W'($urandom()));
        end
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    fail_count       = 0;
    items_sent       = 0;
    builds_sent      = 0;
    reads_sent       = 0;
    cfg_writes       = 0;
    quiet            = 1'b0;
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.op        = OP_LOAD;
    cmd_ch.src_node  = '0;
    cmd_ch.dst_node  = '0;
    cmd_ch.index     = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.num_nodes = '0;
    rsp_ch.ready     = 1'b0;
    reset_graph();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_graph();
    test_node_count_extremes();
    test_count_change_before_build();
    test_store_full();
    test_random_graphs();

    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Run: %0d items (%0d builds, %0d reads), %0d node-count writes, %0d cycles.",
             items_sent, builds_sent, reads_sent, cfg_writes, cycle_count);
    $display("Covered premature and bad reads, range and full rejects, clamped counts.");
    if (fail_count == 0) begin
      $display("edge_list_to_csr_builder_top verification clean");
    end else begin
      $display("edge_list_to_csr_builder_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ecsr_pkg.sv
hw/rtl/ecsr_if.sv
hw/rtl/ecsr_ram.sv
hw/rtl/ecsr_ctrl.sv
hw/rtl/ecsr_dp.sv
hw/rtl/edge_list_to_csr_builder_top.sv
tb/sv/tb_top.sv
